@@ design/time_zone_transition_lookup_core_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the time zone transition lookup core
// Implication macros used by the concurrent checks of the top level.
// ----------------------------------------------------------------------------
`ifndef TIME_ZONE_TRANSITION_LOOKUP_CORE_MACROS_SVH
`define TIME_ZONE_TRANSITION_LOOKUP_CORE_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication.
`define TZTL_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication.
`define TZTL_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define TZTL_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define TZTL_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

@@ design/tztl_pkg.sv @@
// ----------------------------------------------------------------------------
// Time zone transition lookup package
// Field widths, command and status codes, and the shared unit's types.
// ----------------------------------------------------------------------------
package tztl_pkg;

    localparam int TIME_W     = 41;
    localparam int UTC_W      = 32;
    localparam int KEY_W      = 33;
    localparam int OFFS_W     = 32;
    localparam int IDX_W      = 8;
    localparam int ALU_W      = 42;
    localparam int TIDX_CMP_W = 9;

    localparam int DEF_MAX_TRANSITIONS = 256;
    localparam int DEF_MAX_TYPES       = 256;

    localparam logic signed [UTC_W-1:0] UTC_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [UTC_W-1:0] UTC_MIN = 32'sh8000_0000;

    typedef enum logic [1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_TYPE   = 2'd1,
        CMD_TRANS  = 2'd2,
        CMD_QUERY  = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NO_TYPES = 2'd1,
        ST_FULL     = 2'd2,
        ST_BAD_TYPE = 2'd3
    } t_status;

    typedef enum logic {
        ALU_ADD = 1'b0,
        ALU_SUB = 1'b1
    } t_alu_op;

    typedef struct packed {
        t_alu_op                  op;
        logic signed [ALU_W-1:0]  a;
        logic signed [ALU_W-1:0]  b;
    } t_alu_req;

    typedef struct packed {
        logic signed [ALU_W-1:0]  res;
        logic                     lt;
        logic                     eq;
    } t_alu_rsp;

    typedef struct packed {
        logic signed [UTC_W-1:0]  utc;
        logic signed [KEY_W-1:0]  loc;
        logic [IDX_W-1:0]         typ;
    } t_trans_ent;

    typedef struct packed {
        logic signed [OFFS_W-1:0] offset;
        logic                     dst;
        logic [IDX_W-1:0]         abbrev;
    } t_type_ent;

endpackage

@@ design/tztl_if.sv @@
// ----------------------------------------------------------------------------
// Time zone transition lookup channels
// Valid/ready interfaces for the command channel and the result channel.
// ----------------------------------------------------------------------------
interface tztl_in_if import tztl_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [1:0]               cmd;
    logic signed [TIME_W-1:0] time_value;
    logic                     compare_local;
    logic [IDX_W-1:0]         type_index;
    logic signed [OFFS_W-1:0] offset_seconds;
    logic                     dst_flag;
    logic [IDX_W-1:0]         abbrev_index;

    modport source (
        output valid, cmd, time_value, compare_local, type_index,
               offset_seconds, dst_flag, abbrev_index,
        input  ready
    );
    modport sink (
        input  valid, cmd, time_value, compare_local, type_index,
               offset_seconds, dst_flag, abbrev_index,
        output ready
    );
endinterface

interface tztl_out_if import tztl_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [1:0]               status;
    logic [IDX_W-1:0]         found_type;
    logic signed [OFFS_W-1:0] found_offset;
    logic                     found_dst;
    logic [IDX_W-1:0]         found_abbrev;

    modport source (
        output valid, status, found_type, found_offset, found_dst, found_abbrev,
        input  ready
    );
    modport sink (
        input  valid, status, found_type, found_offset, found_dst, found_abbrev,
        output ready
    );
endinterface

@@ design/time_zone_transition_lookup_core.sv @@
// ----------------------------------------------------------------------------
// Time zone transition lookup core
// Holds local time types and transitions and finds the type in force at a
// given time by binary search over the transition table.
//
//   Channel  Port   Direction  Moves
//   command  i_in   in         clear, append type, append transition, query
//   result   o_out  out        status and the selected type, one per command
//
// Clear and append type go from idle straight to the result state; append
// transition passes through an add state first. A query is a binary search
// paced by the single registered read port of the transition memory and the
// one shared subtractor, each search step being a read then a compare.
// Reset clears the state, both counts and output valid only; the memories need no clearing pass.
// A new command is taken once the previous result sits in the output
// register, even while that result still waits for its transfer.
// ----------------------------------------------------------------------------
`include "time_zone_transition_lookup_core_macros.svh"

module time_zone_transition_lookup_core import tztl_pkg::*; #(
    parameter int MAX_TRANSITIONS = DEF_MAX_TRANSITIONS,
    parameter int MAX_TYPES       = DEF_MAX_TYPES
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    tztl_in_if.sink          i_in,
    tztl_out_if.source       o_out
);

    localparam int TR_AW = $clog2(MAX_TRANSITIONS);
    localparam int TR_CW = $clog2(MAX_TRANSITIONS + 1);
    localparam int TY_AW = (MAX_TYPES > 1) ? $clog2(MAX_TYPES) : 1;
    localparam int TY_CW = $clog2(MAX_TYPES + 1);

    typedef enum logic [9:0] {
        S_IDLE      = 10'b00_0000_0001,
        S_ADD       = 10'b00_0000_0010,
        S_K0_CMP    = 10'b00_0000_0100,
        S_SRCH_ADDR = 10'b00_0000_1000,
        S_SRCH_CMP  = 10'b00_0001_0000,
        S_FIX_CMP   = 10'b00_0010_0000,
        S_SEL_ADDR  = 10'b00_0100_0000,
        S_SEL_GET   = 10'b00_1000_0000,
        S_TYPE_ADDR = 10'b01_0000_0000,
        S_DONE      = 10'b10_0000_0000
    } t_state;

    t_state                   r_state, n_state;
    logic [TR_CW-1:0]         r_trans_count, n_trans_count;
    logic [TY_CW-1:0]         r_type_count, n_type_count;
    logic signed [TIME_W-1:0] r_time, n_time;
    logic signed [UTC_W-1:0]  r_utc, n_utc;
    logic                     r_cmp_local, n_cmp_local;
    logic [IDX_W-1:0]         r_tidx, n_tidx;
    t_status                  r_status, n_status;
    logic                     r_found, n_found;
    logic [IDX_W-1:0]         r_sel, n_sel;
    logic [TR_CW-1:0]         r_first, n_first;
    logic [TR_CW-1:0]         r_scount, n_scount;
    logic [TR_CW-1:0]         r_pos, n_pos;

    logic                     r_out_valid, n_out_valid;
    t_status                  r_out_status;
    logic [IDX_W-1:0]         r_out_type;
    logic signed [OFFS_W-1:0] r_out_offset;
    logic                     r_out_dst;
    logic [IDX_W-1:0]         r_out_abbrev;
    logic                     out_load;

    t_trans_ent               r_trans_mem [MAX_TRANSITIONS];
    t_trans_ent               r_trans_q;
    logic                     trans_we;
    logic [TR_AW-1:0]         trans_waddr;
    logic [TR_AW-1:0]         trans_raddr;
    t_trans_ent               trans_wdata;

    t_type_ent                r_type_mem [MAX_TYPES];
    t_type_ent                r_type_q;
    logic                     type_we;
    logic [TY_AW-1:0]         type_raddr;
    t_type_ent                type_wdata;

    t_alu_req                 alu_req;
    t_alu_rsp                 alu_rsp;

    logic                     accept;
    logic signed [UTC_W-1:0]  utc_sat;
    logic [TR_CW-1:0]         srch_pos;

    assign i_in.ready = (r_state == S_IDLE);
    assign accept     = i_in.valid && i_in.ready;

    // Transition times saturate to the signed 32-bit range.
    always_comb begin
        if (i_in.time_value[TIME_W-1:UTC_W-1] == '0 ||
            i_in.time_value[TIME_W-1:UTC_W-1] == '1) begin
            utc_sat = i_in.time_value[UTC_W-1:0];
        end else if (i_in.time_value[TIME_W-1]) begin
            utc_sat = UTC_MIN;
        end else begin
            utc_sat = UTC_MAX;
        end
    end

    // Lower-bound probe: middle of the remaining range, or its start once
    // the range is empty.
    assign srch_pos = r_first + (r_scount >> 1);

    always_comb begin
        alu_req.op = ALU_SUB;
        alu_req.a  = r_cmp_local ? ALU_W'(r_trans_q.loc) : ALU_W'(r_trans_q.utc);
        alu_req.b  = ALU_W'(r_time);
        if (r_state == S_ADD) begin
            alu_req.op = ALU_ADD;
            alu_req.a  = ALU_W'(r_utc);
            alu_req.b  = ALU_W'(r_type_q.offset);
        end
    end

    tztl_alu u_alu (
        .i_req (alu_req),
        .o_rsp (alu_rsp)
    );

    always_comb begin
        n_state       = r_state;
        n_trans_count = r_trans_count;
        n_type_count  = r_type_count;
        n_time        = r_time;
        n_utc         = r_utc;
        n_cmp_local   = r_cmp_local;
        n_tidx        = r_tidx;
        n_status      = r_status;
        n_found       = r_found;
        n_sel         = r_sel;
        n_first       = r_first;
        n_scount      = r_scount;
        n_pos         = r_pos;
        out_load      = 1'b0;
        n_out_valid   = r_out_valid && !o_out.ready;

        trans_we      = 1'b0;
        trans_waddr   = r_trans_count[TR_AW-1:0];
        trans_raddr   = r_pos[TR_AW-1:0];
        trans_wdata   = '{utc: r_utc, loc: alu_rsp.res[KEY_W-1:0], typ: r_tidx};

        type_we       = 1'b0;
        type_raddr    = r_sel[TY_AW-1:0];
        type_wdata    = '{offset: i_in.offset_seconds, dst: i_in.dst_flag,
                          abbrev: i_in.abbrev_index};

        unique case (r_state)
            S_IDLE: begin
                // First key and the named type are fetched at once, so the
                // next state finds them ready.
                trans_raddr = '0;
                type_raddr  = i_in.type_index[TY_AW-1:0];
                if (accept) begin
                    n_time      = i_in.time_value;
                    n_utc       = utc_sat;
                    n_cmp_local = i_in.compare_local;
                    n_tidx      = i_in.type_index;
                    n_status    = ST_OK;
                    n_found     = 1'b0;
                    n_sel       = '0;
                    n_state     = S_DONE;
                    unique case (t_cmd'(i_in.cmd))
                        CMD_CLEAR: begin
                            n_trans_count = '0;
                            n_type_count  = '0;
                        end
                        CMD_TYPE: begin
                            if (r_type_count == TY_CW'(MAX_TYPES)) begin
                                n_status = ST_FULL;
                            end else begin
                                type_we      = 1'b1;
                                n_type_count = r_type_count + TY_CW'(1);
                            end
                        end
                        CMD_TRANS: begin
                            priority if (r_type_count == '0) begin
                                n_status = ST_NO_TYPES;
                            end else if (TIDX_CMP_W'(i_in.type_index) >=
                                         TIDX_CMP_W'(r_type_count)) begin
                                n_status = ST_BAD_TYPE;
                            end else if (r_trans_count == TR_CW'(MAX_TRANSITIONS)) begin
                                n_status = ST_FULL;
                            end else begin
                                n_state = S_ADD;
                            end
                        end
                        CMD_QUERY: begin
                            if (r_type_count == '0) begin
                                n_status = ST_NO_TYPES;
                            end else begin
                                n_found = 1'b1;
                                if (r_trans_count == '0) begin
                                    n_state = S_TYPE_ADDR;
                                end else begin
                                    n_state = S_K0_CMP;
                                end
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_ADD: begin
                trans_we      = 1'b1;
                n_trans_count = r_trans_count + TR_CW'(1);
                n_state       = S_DONE;
            end
            S_K0_CMP: begin
                // A time before the first transition selects type 0.
                if (!alu_rsp.lt && !alu_rsp.eq) begin
                    n_sel   = '0;
                    n_state = S_TYPE_ADDR;
                end else begin
                    n_first  = '0;
                    n_scount = r_trans_count;
                    n_state  = S_SRCH_ADDR;
                end
            end
            S_SRCH_ADDR: begin
                trans_raddr = srch_pos[TR_AW-1:0];
                n_pos       = srch_pos;
                if (r_scount != '0) begin
                    n_state = S_SRCH_CMP;
                end else if (r_first < r_trans_count) begin
                    n_state = S_FIX_CMP;
                end else begin
                    n_pos   = r_trans_count - TR_CW'(1);
                    n_state = S_SEL_ADDR;
                end
            end
            S_SRCH_CMP: begin
                if (alu_rsp.lt) begin
                    n_first  = r_pos + TR_CW'(1);
                    n_scount = r_scount - (r_scount >> 1) - TR_CW'(1);
                end else begin
                    n_scount = r_scount >> 1;
                end
                n_state = S_SRCH_ADDR;
            end
            S_FIX_CMP: begin
                // Without an exact match the transition before the bound
                // is the one in force.
                if (!alu_rsp.eq && r_pos != '0) begin
                    n_pos = r_pos - TR_CW'(1);
                end
                n_state = S_SEL_ADDR;
            end
            S_SEL_ADDR: begin
                n_state = S_SEL_GET;
            end
            S_SEL_GET: begin
                n_sel   = r_trans_q.typ;
                n_state = S_TYPE_ADDR;
            end
            S_TYPE_ADDR: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || o_out.ready) begin
                    out_load    = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_trans_count <= '0;
            r_type_count  <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_trans_count <= n_trans_count;
            r_type_count  <= n_type_count;
            r_out_valid   <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_time      <= n_time;
        r_utc       <= n_utc;
        r_cmp_local <= n_cmp_local;
        r_tidx      <= n_tidx;
        r_status    <= n_status;
        r_found     <= n_found;
        r_sel       <= n_sel;
        r_first     <= n_first;
        r_scount    <= n_scount;
        r_pos       <= n_pos;
        if (out_load) begin
            r_out_status <= r_status;
            r_out_type   <= r_found ? r_sel : '0;
            r_out_offset <= r_found ? r_type_q.offset : '0;
            r_out_dst    <= r_found ? r_type_q.dst : 1'b0;
            r_out_abbrev <= r_found ? r_type_q.abbrev : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (trans_we) begin
            r_trans_mem[trans_waddr] <= trans_wdata;
        end
        r_trans_q <= r_trans_mem[trans_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (type_we) begin
            r_type_mem[r_type_count[TY_AW-1:0]] <= type_wdata;
        end
        r_type_q <= r_type_mem[type_raddr];
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.status       = r_out_status;
    assign o_out.found_type   = r_out_type;
    assign o_out.found_offset = r_out_offset;
    assign o_out.found_dst    = r_out_dst;
    assign o_out.found_abbrev = r_out_abbrev;

    `TZTL_ASSERT_IMP(a_trans_count_bound, i_clk, i_rst_n, 1'b1, r_trans_count <= TR_CW'(MAX_TRANSITIONS), "transition count beyond table depth")
    `TZTL_ASSERT_NXT(a_busy_after_accept, i_clk, i_rst_n, i_in.valid && i_in.ready, !i_in.ready, "command accepted twice in a row")
    `TZTL_ASSERT_NXT(a_search_shrinks, i_clk, i_rst_n, r_state == S_SRCH_CMP, r_scount < $past(r_scount), "search range failed to shrink")
    `TZTL_ASSERT_IMP(a_found_is_ok, i_clk, i_rst_n, r_state == S_DONE && r_found, r_status == ST_OK, "type returned with an error status")

endmodule

@@ design/tztl_alu.sv @@
// ----------------------------------------------------------------------------
// Shared add/compare unit
// One wide signed adder that forms local keys on append and compares keys
// against the looked-up time during a search.
// ----------------------------------------------------------------------------
module tztl_alu import tztl_pkg::*; (
    input  t_alu_req i_req,
    output t_alu_rsp o_rsp
);

    logic signed [ALU_W-1:0] res;

    always_comb begin
        if (i_req.op == ALU_ADD) begin
            res = i_req.a + i_req.b;
        end else begin
            res = i_req.a - i_req.b;
        end
    end

    // Operands are sign-extended one bit wider than the widest operand, so the sign of the
    // difference never overflows.
    assign o_rsp.res = res;
    assign o_rsp.lt  = res[ALU_W-1];
    assign o_rsp.eq  = (res == '0);

endmodule

@@ dv/time_zone_transition_lookup_core_tb.sv @@
// ----------------------------------------------------------------------------
// Time zone transition lookup core testbench
// Drives clear, append-type, append-transition and query commands through
// the command channel and checks every result, in order, against a local
// predictor of the type and transition tables. Both channels stall at random.
// Tests run in turn: boundary cases, full tables, then random sessions of
// well-formed table builds and lookups with some malformed commands mixed in.
// ----------------------------------------------------------------------------
module time_zone_transition_lookup_core_tb;
    import tztl_pkg::*;

    localparam int    TRANS_CAP    = DEF_MAX_TRANSITIONS;
    localparam int    TYPE_CAP     = DEF_MAX_TYPES;
    localparam int    TARGET_ITEMS = 1650;
    localparam longint T_MIN41     = -(64'sd1 <<< (TIME_W - 1));
    localparam longint T_MAX41     = (64'sd1 <<< (TIME_W - 1)) - 1;
    localparam logic signed [OFFS_W-1:0] OFFS_MIN = 32'sh8000_0000;
    localparam logic signed [OFFS_W-1:0] OFFS_MAX = 32'sh7FFF_FFFF;

    typedef struct {
        t_cmd                     cmd;
        logic signed [TIME_W-1:0] tval;
        bit                       by_local;
        logic [IDX_W-1:0]         tidx;
        logic signed [OFFS_W-1:0] offs;
        bit                       dst;
        logic [IDX_W-1:0]         abbr;
    } t_cmd_item;

    typedef struct {
        t_status                  status;
        logic [IDX_W-1:0]         ftype;
        logic signed [OFFS_W-1:0] foffs;
        logic                     fdst;
        logic [IDX_W-1:0]         fabbr;
    } t_outcome;

    logic i_clk;
    logic i_rst_n;

    tztl_in_if  in_ch ();
    tztl_out_if out_ch ();

    time_zone_transition_lookup_core #(
        .MAX_TRANSITIONS(TRANS_CAP),
        .MAX_TYPES(TYPE_CAP)
    ) uut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in(in_ch),
        .o_out(out_ch)
    );

    // Predicted contents of the two tables.
    logic signed [UTC_W-1:0]  tz_utc       [TRANS_CAP];
    logic signed [KEY_W-1:0]  tz_local     [TRANS_CAP];
    logic [IDX_W-1:0]         tz_type      [TRANS_CAP];
    logic signed [OFFS_W-1:0] zone_offset  [TYPE_CAP];
    logic                     zone_dst     [TYPE_CAP];
    logic [IDX_W-1:0]         zone_abbrev  [TYPE_CAP];
    int                       n_trans;
    int                       n_types;

    t_outcome expected_q [$];
    int       n_sent;
    int       n_queries;
    int       n_checked;
    int       n_fail;
    bit       send_calm;
    bit       recv_calm;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #20_000_000;
        $display("tb: failure");
        $finish;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic longint key_of(input int i, input bit by_loc);
        return by_loc ? longint'(tz_local[i]) : longint'(tz_utc[i]);
    endfunction

    // Lower bound: first position whose key is not below t.
    function automatic int first_not_below(input longint t, input bit by_loc);
        int first;
        int count;
        int step;
        int pos;
        first = 0;
        count = n_trans;
        while (count > 0) begin
            step = count / 2;
            pos  = first + step;
            if (key_of(pos, by_loc) < t) begin
                first = pos + 1;
                count -= step + 1;
            end else begin
                count = step;
            end
        end
        return first;
    endfunction

    function automatic t_outcome apply_command(input t_cmd_item it);
        t_outcome res;
        longint   t;
        longint   u;
        longint   lsum;
        int       pos;
        int       sel;
        res.status = ST_OK;
        res.ftype  = '0;
        res.foffs  = '0;
        res.fdst   = 1'b0;
        res.fabbr  = '0;
        t = it.tval;
        unique case (it.cmd)
            CMD_CLEAR: begin
                n_trans = 0;
                n_types = 0;
            end
            CMD_TYPE: begin
                if (n_types >= TYPE_CAP) begin
                    res.status = ST_FULL;
                end else begin
                    zone_offset[n_types] = it.offs;
                    zone_dst[n_types]    = it.dst;
                    zone_abbrev[n_types] = it.abbr;
                    n_types++;
                end
            end
            CMD_TRANS: begin
                if (n_types == 0) begin
                    res.status = ST_NO_TYPES;
                end else if (it.tidx >= n_types) begin
                    res.status = ST_BAD_TYPE;
                end else if (n_trans >= TRANS_CAP) begin
                    res.status = ST_FULL;
                end else begin
                    u = t;
                    if (u > longint'(UTC_MAX)) u = longint'(UTC_MAX);
                    if (u < longint'(UTC_MIN)) u = longint'(UTC_MIN);
                    lsum = u + longint'(zone_offset[it.tidx]);
                    tz_utc[n_trans]   = u[UTC_W-1:0];
                    tz_local[n_trans] = lsum[KEY_W-1:0];
                    tz_type[n_trans]  = it.tidx;
                    n_trans++;
                end
            end
            CMD_QUERY: begin
                if (n_types == 0) begin
                    res.status = ST_NO_TYPES;
                end else begin
                    if (n_trans == 0 || t < key_of(0, it.by_local)) begin
                        sel = 0;
                    end else begin
                        pos = first_not_below(t, it.by_local);
                        if (pos < n_trans) begin
                            if (key_of(pos, it.by_local) != t && pos > 0) pos--;
                        end else begin
                            pos = n_trans - 1;
                        end
                        sel = tz_type[pos];
                    end
                    res.ftype = sel[IDX_W-1:0];
                    res.foffs = zone_offset[sel];
                    res.fdst  = zone_dst[sel];
                    res.fabbr = zone_abbrev[sel];
                end
            end
        endcase
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Item construction
    // ------------------------------------------------------------------
    function automatic logic signed [TIME_W-1:0] rand_time();
        logic [63:0] r;
        r = {$urandom, $urandom};
        return r[TIME_W-1:0];
    endfunction

    function automatic logic signed [OFFS_W-1:0] rand_offset();
        if ($urandom_range(0, 3) == 0) return $urandom;
        // Mostly realistic offsets on a quarter-hour grid.
        return (int'($urandom_range(0, 104)) - 48) * 900;
    endfunction

    // Every field random; the builders below then set what matters.
    function automatic t_cmd_item noise_item();
        t_cmd_item it;
        it.cmd      = t_cmd'($urandom_range(0, 3));
        it.tval     = rand_time();
        it.by_local = 1'($urandom_range(0, 1));
        it.tidx     = IDX_W'($urandom_range(0, 255));
        it.offs     = $urandom;
        it.dst      = 1'($urandom_range(0, 1));
        it.abbr     = IDX_W'($urandom_range(0, 255));
        return it;
    endfunction

    function automatic t_cmd_item make_clear();
        t_cmd_item it;
        it = noise_item();
        it.cmd = CMD_CLEAR;
        return it;
    endfunction

    function automatic t_cmd_item make_type(input logic signed [OFFS_W-1:0] offs,
                                            input bit dst,
                                            input logic [IDX_W-1:0] abbr);
        t_cmd_item it;
        it = noise_item();
        it.cmd  = CMD_TYPE;
        it.offs = offs;
        it.dst  = dst;
        it.abbr = abbr;
        return it;
    endfunction

    function automatic t_cmd_item make_trans(input longint t, input int idx);
        t_cmd_item it;
        it = noise_item();
        it.cmd  = CMD_TRANS;
        it.tval = t[TIME_W-1:0];
        it.tidx = idx[IDX_W-1:0];
        return it;
    endfunction

    function automatic t_cmd_item make_query(input longint t, input bit by_loc);
        t_cmd_item it;
        it = noise_item();
        it.cmd      = CMD_QUERY;
        it.tval     = t[TIME_W-1:0];
        it.by_local = by_loc;
        return it;
    endfunction

    // Query times cluster on the stored keys so that exact hits, near
    // misses and both ends of the table are exercised.
    function automatic longint pick_query_time(input bit by_loc);
        longint base;
        if (n_trans == 0 || $urandom_range(0, 7) == 0) return longint'(rand_time());
        base = key_of($urandom_range(0, n_trans - 1), by_loc);
        case ($urandom_range(0, 5))
            0:       return key_of(0, by_loc) - 1;
            1:       return key_of(n_trans - 1, by_loc) + $urandom_range(0, 1000);
            2:       return base - 1;
            3:       return base + 1;
            default: return base;
        endcase
    endfunction

    function automatic int draw_wait(input bit calm);
        return calm ? 0 : $urandom_range(0, 16);
    endfunction

    // ------------------------------------------------------------------
    // Command channel
    // ------------------------------------------------------------------
    task automatic send_item(input t_cmd_item it);
        int gap;
        gap = draw_wait(send_calm);
        @(negedge i_clk);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_ch.cmd            <= it.cmd;
        in_ch.time_value     <= it.tval;
        in_ch.compare_local  <= it.by_local;
        in_ch.type_index     <= it.tidx;
        in_ch.offset_seconds <= it.offs;
        in_ch.dst_flag       <= it.dst;
        in_ch.abbrev_index   <= it.abbr;
        in_ch.valid          <= 1'b1;
        do @(posedge i_clk); while (!in_ch.ready);
        expected_q.insert(expected_q.size(), apply_command(it));
        n_sent++;
        if (it.cmd == CMD_QUERY) n_queries++;
        if ($urandom_range(0, 39) == 0) send_calm = !send_calm;
    endtask

    // ------------------------------------------------------------------
    // Result channel
    // ------------------------------------------------------------------
    initial begin
        t_outcome exp;
        int       stall;
        out_ch.ready = 1'b0;
        recv_calm    = 1'b0;
        @(posedge i_rst_n);
        forever begin
            stall = draw_wait(recv_calm);
            @(negedge i_clk);
            if (stall > 0) begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!out_ch.valid);
            if ($urandom_range(0, 39) == 0) recv_calm = !recv_calm;
            if (expected_q.size() == 0) begin
                $error("unexpected result transfer with status %0d", out_ch.status);
                n_fail++;
            end else begin
                exp = expected_q.pop_front();
                n_checked++;
                if (out_ch.status !== exp.status) begin
                    $error("status: expected %0d, got %0d", exp.status, out_ch.status);
                    n_fail++;
                end
                if (out_ch.found_type !== exp.ftype) begin
                    $error("found_type: expected %0d, got %0d", exp.ftype, out_ch.found_type);
                    n_fail++;
                end
                if (out_ch.found_offset !== exp.foffs) begin
                    $error("found_offset: expected %0d, got %0d",
                           exp.foffs, out_ch.found_offset);
                    n_fail++;
                end
                if (out_ch.found_dst !== exp.fdst) begin
                    $error("found_dst: expected %0d, got %0d", exp.fdst, out_ch.found_dst);
                    n_fail++;
                end
                if (out_ch.found_abbrev !== exp.fabbr) begin
                    $error("found_abbrev: expected %0d, got %0d",
                           exp.fabbr, out_ch.found_abbrev);
                    n_fail++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_directed_edges();
        // Nothing loaded yet, so both the query and the appends are refused.
        send_item(make_query(0, 1'b0));
        send_item(make_trans(0, 0));
        send_item(make_trans(0, 255));
        send_item(make_type(OFFS_MIN, 1'b1, 8'd255));
        send_item(make_type(OFFS_MAX, 1'b0, 8'd0));
        send_item(make_type(32'sd3600, 1'b1, 8'd170));
        // Types but no transitions: type 0 whatever the time; out-of-range type indices are refused.
        send_item(make_query(0, 1'b0));
        send_item(make_query(T_MAX41, 1'b1));
        send_item(make_trans(0, 3));
        send_item(make_trans(0, 255));
        // Saturating UTC times at both ends, and a pair of equal keys.
        send_item(make_trans(T_MIN41, 0));
        send_item(make_trans(-5, 2));
        send_item(make_trans(0, 1));
        send_item(make_trans(0, 2));
        send_item(make_trans(T_MAX41, 1));
        send_item(make_query(T_MIN41, 1'b0));
        send_item(make_query(longint'(UTC_MIN), 1'b0));
        send_item(make_query(0, 1'b0));
        send_item(make_query(-1, 1'b0));
        send_item(make_query(T_MAX41, 1'b0));
        // The local keys here are not ascending.
        send_item(make_query(3595, 1'b1));
        send_item(make_query(-(64'sd1 <<< 32), 1'b1));
        send_item(make_query((64'sd1 <<< 32) - 2, 1'b1));
        send_item(make_clear());
        send_item(make_query(0, 1'b1));
    endtask

    task automatic test_table_limits();
        longint t_now;
        int     k;
        // Few types and a full transition table: an unknown type index is
        // reported before the table being full.
        send_item(make_clear());
        send_item(make_type(rand_offset(), 1'b0, 8'd1));
        send_item(make_type(rand_offset(), 1'b1, 8'd2));
        for (k = 0; k < TRANS_CAP; k++) send_item(make_trans(longint'(k) * 3600 - 500000, k % 2));
        send_item(make_trans(0, 200));
        send_item(make_trans(0, 1));
        repeat (6) send_item(make_query(pick_query_time(k[0]), k[0]));
        // Both tables filled to the brim, then deep searches.
        send_item(make_clear());
        for (k = 0; k <= TYPE_CAP; k++) begin
            send_item(make_type(rand_offset(), 1'($urandom_range(0, 1)),
                                IDX_W'($urandom_range(0, 255))));
        end
        t_now = longint'(rand_time()) >>> 9;
        for (k = 0; k <= TRANS_CAP; k++) begin
            send_item(make_trans(t_now, $urandom_range(0, TYPE_CAP - 1)));
            t_now += longint'($urandom_range(0, 100000));
        end
        for (k = 0; k < 40; k++) send_item(make_query(pick_query_time(k[0]), k[0]));
    endtask

    task automatic run_session();
        int     n_ty;
        int     n_tr;
        int     n_q;
        int     k;
        longint t_now;
        bit     by_loc;
        if ($urandom_range(0, 5) == 0) repeat ($urandom_range(1, 4)) send_item(noise_item());
        send_item(make_clear());
        n_ty = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 60) : $urandom_range(1, 12);
        for (k = 0; k < n_ty; k++) begin
            send_item(make_type(rand_offset(), 1'($urandom_range(0, 1)),
                                IDX_W'($urandom_range(0, 255))));
        end
        if ($urandom_range(0, 3) == 0) t_now = longint'(rand_time());
        else t_now = longint'($urandom_range(0, 2000000000)) - 64'sd1000000000;
        n_tr = $urandom_range(0, 30);
        for (k = 0; k < n_tr; k++) begin
            if ($urandom_range(0, 15) == 0) begin
                send_item(make_trans(t_now, $urandom_range(n_ty, 255)));
            end else begin
                send_item(make_trans(t_now, $urandom_range(0, n_ty - 1)));
            end
            // Mostly ascending, with the odd repeat and the odd step back.
            if ($urandom_range(0, 11) == 0) t_now -= longint'($urandom_range(1, 20000000));
            else if ($urandom_range(0, 9) != 0) t_now += longint'($urandom_range(1, 20000000));
            if (t_now > T_MAX41) t_now = T_MAX41;
            if (t_now < T_MIN41) t_now = T_MIN41;
        end
        n_q = $urandom_range(4, 24);
        for (k = 0; k < n_q; k++) begin
            if ($urandom_range(0, 19) == 0) begin
                send_item(make_type(rand_offset(), 1'($urandom_range(0, 1)),
                                    IDX_W'($urandom_range(0, 255))));
            end
            by_loc = 1'($urandom_range(0, 1));
            send_item(make_query(pick_query_time(by_loc), by_loc));
        end
    endtask

    task automatic test_random_sessions();
        while (n_sent < TARGET_ITEMS) run_session();
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        int k;
        n_trans   = 0;
        n_types   = 0;
        n_sent    = 0;
        n_queries = 0;
        n_checked = 0;
        n_fail    = 0;
        send_calm = 1'b0;
        i_rst_n              = 1'b0;
        in_ch.valid          = 1'b0;
        in_ch.cmd            = CMD_CLEAR;
        in_ch.time_value     = '0;
        in_ch.compare_local  = 1'b0;
        in_ch.type_index     = '0;
        in_ch.offset_seconds = '0;
        in_ch.dst_flag       = 1'b0;
        in_ch.abbrev_index   = '0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_edges();
        test_table_limits();
        test_random_sessions();

        @(negedge i_clk);
        in_ch.valid <= 1'b0;
        k = 0;
        while (expected_q.size() != 0 && k < 5000) begin
            @(posedge i_clk);
            k++;
        end
        repeat (40) @(posedge i_clk);
        if (expected_q.size() != 0) begin
            $error("%0d results never arrived", expected_q.size());
            n_fail++;
        end
        $display("summary: %0d commands driven (%0d lookups), %0d results compared,",
                 n_sent, n_queries, n_checked);
        $display("summary: including saturated times, full tables and 256-entry searches.");
        if (n_fail == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

@@ time_zone_transition_lookup_core.f @@
+incdir+design
design/tztl_pkg.sv
design/tztl_if.sv
design/tztl_alu.sv
design/time_zone_transition_lookup_core.sv
dv/time_zone_transition_lookup_core_tb.sv
